FILE: rtl/core/idsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsp_pkg
// Shared types and constants for the id/string line parser: beat layouts,
// result kinds, parser modes and the code units that the grammar knows.
// ----------------------------------------------------------------------------
package idsp_pkg;

    // code units of the grammar
    localparam logic [15:0] UNIT_BOM       = 16'hFEFF;
    localparam logic [15:0] UNIT_LF        = 16'h000A;
    localparam logic [15:0] UNIT_CR        = 16'h000D;
    localparam logic [15:0] UNIT_EQUALS    = 16'h003D;
    localparam logic [15:0] UNIT_QUOTE     = 16'h0022;
    localparam logic [15:0] UNIT_BACKSLASH = 16'h005C;
    localparam logic [15:0] UNIT_LOWER_N   = 16'h006E;
    localparam logic [15:0] UNIT_DIGIT_0   = 16'h0030;
    localparam logic [15:0] UNIT_DIGIT_9   = 16'h0039;

    // most results one input beat can cause
    localparam int MAX_RESULTS = 3;
    // default depth of the result queue
    localparam int QUEUE_DEPTH_DEF = 4;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_ERROR    = 2'd2,
        KIND_ABANDON  = 2'd3
    } t_kind;

    // parser modes, one-hot
    typedef enum logic [5:0] {
        MODE_NEWLINE = 6'b000001,
        MODE_COMMENT = 6'b000010,
        MODE_NUMBER  = 6'b000100,
        MODE_QUOTE   = 6'b001000,
        MODE_STRING  = 6'b010000,
        MODE_HALTED  = 6'b100000
    } t_mode;

    // input beat
    typedef struct packed {
        logic [15:0] code_unit;
        logic        first_of_file;
        logic        last_of_file;
    } t_in_beat;

    // result beat
    typedef struct packed {
        t_kind       kind;
        logic [31:0] entry_id;
        logic [15:0] char_out;
        logic        last_of_step;
    } t_out_beat;

    // results pushed into the queue for one input beat
    typedef struct packed {
        logic [1:0]                       n;
        t_out_beat [MAX_RESULTS-1:0]      beats;
    } t_push;

    // outcome of parsing one code unit
    typedef struct packed {
        t_push       push;
        t_mode       mode;
        logic [31:0] id;
        logic        pb;
    } t_step;

endpackage

FILE: rtl/core/idsp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsp_step
// Parse logic for one code unit: from the current parser state and the
// input beat, forms the next state and up to three result beats.
// ----------------------------------------------------------------------------
module idsp_step
    import idsp_pkg::*;
(
    input  t_in_beat    i_beat,
    input  t_mode       i_mode,
    input  logic [31:0] i_id,
    input  logic        i_pb,
    output t_step       o_step
);

    logic [15:0] w_c;
    logic        w_digit;
    t_mode       w_mode;
    logic [31:0] w_id;
    logic        w_pb;

    assign w_c     = i_beat.code_unit;
    assign w_digit = (w_c >= UNIT_DIGIT_0) && (w_c <= UNIT_DIGIT_9);

    // file start restarts the parser
    assign w_mode = i_beat.first_of_file ? MODE_NEWLINE : i_mode;
    assign w_id   = i_beat.first_of_file ? 32'd0 : i_id;
    assign w_pb   = i_beat.first_of_file ? 1'b0 : i_pb;

    // mode transitions and result forming
    always_comb begin
        logic [1:0] cnt;
        logic       escaped;
        cnt     = 2'd0;
        escaped = 1'b0;
        o_step  = '0;
        o_step.mode = w_mode;
        o_step.id   = w_id;
        o_step.pb   = w_pb;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            o_step.push.beats[i].kind     = KIND_CHAR;
            o_step.push.beats[i].entry_id = w_id;
        end

        case (w_mode)
            MODE_NEWLINE: begin
                if (w_digit) begin
                    o_step.id   = {28'd0, w_c[3:0]};
                    o_step.mode = MODE_NUMBER;
                end else begin
                    o_step.mode = MODE_COMMENT;
                end
            end
            MODE_COMMENT: begin
                if (w_c == UNIT_LF) begin
                    o_step.mode = MODE_NEWLINE;
                end
            end
            MODE_NUMBER: begin
                if (w_digit) begin
                    o_step.id = {w_id[28:0], 3'b000} + {w_id[30:0], 1'b0}
                              + {28'd0, w_c[3:0]};
                end else if (w_c == UNIT_EQUALS) begin
                    o_step.mode = MODE_QUOTE;
                end else begin
                    o_step.push.beats[cnt].kind = KIND_ERROR;
                    cnt = cnt + 2'd1;
                    o_step.mode = MODE_HALTED;
                end
            end
            MODE_QUOTE: begin
                if (w_c == UNIT_QUOTE) begin
                    o_step.pb   = 1'b0;
                    o_step.mode = MODE_STRING;
                end else if (w_c == UNIT_LF) begin
                    o_step.mode = MODE_NEWLINE;
                end
            end
            MODE_STRING: begin
                // flush a pending backslash first
                if (w_pb) begin
                    o_step.pb = 1'b0;
                    if (w_c == UNIT_LOWER_N) begin
                        o_step.push.beats[cnt].char_out = UNIT_CR;
                        cnt = cnt + 2'd1;
                        o_step.push.beats[cnt].char_out = UNIT_LF;
                        cnt = cnt + 2'd1;
                        escaped = 1'b1;
                    end else begin
                        o_step.push.beats[cnt].char_out = UNIT_BACKSLASH;
                        cnt = cnt + 2'd1;
                    end
                end
                if (!escaped) begin
                    if (w_c == UNIT_QUOTE) begin
                        o_step.push.beats[cnt].kind = KIND_COMPLETE;
                        cnt = cnt + 2'd1;
                        o_step.mode = MODE_COMMENT;
                    end else if (w_c == UNIT_BACKSLASH) begin
                        o_step.pb = 1'b1;
                    end else begin
                        o_step.push.beats[cnt].char_out = w_c;
                        cnt = cnt + 2'd1;
                    end
                end
            end
            default: begin
                // halted or unused code: ignore the unit
            end
        endcase

        // file end inside an open string
        if (i_beat.last_of_file && (o_step.mode == MODE_STRING)) begin
            o_step.push.beats[cnt].kind     = KIND_ABANDON;
            o_step.push.beats[cnt].char_out = 16'd0;
            cnt = cnt + 2'd1;
            o_step.pb   = 1'b0;
            o_step.mode = MODE_NEWLINE;
        end

        // byte-order mark at file start: skipped after the restart
        if (i_beat.first_of_file && (w_c == UNIT_BOM)) begin
            cnt         = 2'd0;
            o_step.mode = MODE_NEWLINE;
            o_step.id   = 32'd0;
            o_step.pb   = 1'b0;
        end

        // mark the final result of this beat
        for (int i = 0; i < MAX_RESULTS; i++) begin
            o_step.push.beats[i].last_of_step = (cnt != 2'd0) && (2'(i) == cnt - 2'd1);
        end
        o_step.push.n = cnt;
    end

endmodule

FILE: rtl/core/idsp_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsp_out_queue
// Shift queue of result beats: takes up to three beats per cycle at the tail,
// hands one beat per cycle from the head to the output channel unless stalled.
// ----------------------------------------------------------------------------
module idsp_out_queue
    import idsp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_room,
    output logic      o_valid,
    output t_out_beat o_beat,
    input  logic      i_stall
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] w_keep;
    logic          w_pop;
    t_out_beat     r_q [DEPTH];
    t_out_beat     n_q [DEPTH];

    // head beat leaves when not stalled
    assign w_pop   = (r_count != '0) && !i_stall;
    assign w_keep  = r_count - CW'(w_pop);
    assign n_count = w_keep + CW'(i_push.n);
    assign o_valid = (r_count != '0);
    assign o_beat  = r_q[0];
    assign o_room  = (r_count <= CW'(DEPTH - MAX_RESULTS));

    // shift down on pop, append pushed beats behind the kept ones
    always_comb begin
        logic [CW-1:0] slot;
        for (int i = 0; i < DEPTH; i++) begin
            slot   = CW'(i) - w_keep;
            n_q[i] = r_q[i];
            if (CW'(i) < w_keep) begin
                if (w_pop) begin
                    n_q[i] = r_q[(i < DEPTH - 1) ? IW'(i + 1) : IW'(i)];
                end
            end else if (slot < CW'(i_push.n)) begin
                n_q[i] = i_push.beats[slot[1:0]];
            end
        end
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |-> ((w_keep + CW'(i_push.n)) <= CW'(DEPTH)))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_room |-> (i_push.n == 2'd0))
        else $error("push while queue has no room");

endmodule

FILE: rtl/core/id_string_line_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_string_line_parser_unit
// Parser for UTF-16 text lines of the form id = "string", streaming string
// characters tagged with their decimal id.
// ----------------------------------------------------------------------------
// One code unit is parsed per cycle unless the input stalls; the parser
// state updates in the cycle the unit is accepted and its results (none to
// three) enter a result queue of QUEUE_DEPTH beats, which drains one beat
// per cycle unless the receiver stalls. The input stalls while more than
// QUEUE_DEPTH-3 beats wait, so without receiver stalls a steady stream of
// units that each yield at most one result flows at one unit per cycle; a
// unit with two or three results (newline escape, file end in a string)
// can stall the input. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module id_string_line_parser_unit
    import idsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_beat  i_beat,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_beat o_beat,
    input  logic      i_stall
);

    t_mode       r_mode;
    logic [31:0] r_id;
    logic        r_pb;
    t_step       w_step;
    t_push       w_push;
    logic        w_room;
    logic        w_accept;

    assign o_stall  = !w_room;
    assign w_accept = i_valid && !o_stall;

    // parse logic for the incoming unit
    idsp_step u_step (
        .i_beat (i_beat),
        .i_mode (r_mode),
        .i_id   (r_id),
        .i_pb   (r_pb),
        .o_step (w_step)
    );

    // results enter the queue only for an accepted beat
    always_comb begin
        w_push = w_step.push;
        if (!w_accept) begin
            w_push.n = 2'd0;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NEWLINE;
            r_id   <= 32'd0;
            r_pb   <= 1'b0;
        end else if (w_accept) begin
            r_mode <= w_step.mode;
            r_id   <= w_step.id;
            r_pb   <= w_step.pb;
        end
    end

    // result queue
    idsp_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_valid),
        .o_beat  (o_beat),
        .i_stall (i_stall)
    );

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_mode == MODE_HALTED) && !i_beat.first_of_file)
        |-> (w_push.n == 2'd0))
        else $error("halted parser produced a result");

    a_bom_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_beat.first_of_file && (i_beat.code_unit == UNIT_BOM))
        |=> ((r_mode == MODE_NEWLINE) && (r_id == 32'd0) && !r_pb))
        else $error("byte-order mark did not restart the parser");

endmodule

FILE: tb/sv/idsp_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsp_result_checker
// Watches both channels of the id/string line parser, predicts the result
// beats of every accepted code unit and compares them in order with the
// result beats that leave the block.
// ----------------------------------------------------------------------------
module idsp_result_checker
    import idsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_beat,
    input  logic      i_in_stall,
    input  logic      i_out_valid,
    input  t_out_beat i_out_beat,
    input  logic      i_out_stall,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);

    // predicted parser state
    t_mode       parse_mode;
    logic [31:0] cur_id;
    logic        pend_bs;

    // results of the unit being predicted
    t_out_beat   step_beats [MAX_RESULTS];
    int          step_count;

    // result beats still to come, oldest first
    t_out_beat   expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        parse_mode   = MODE_NEWLINE;
        cur_id       = '0;
        pend_bs      = 1'b0;
        step_count   = 0;
    end

    function automatic logic is_digit(logic [15:0] cu);
        return cu >= UNIT_DIGIT_0 && cu <= UNIT_DIGIT_9;
    endfunction

    function automatic void add_result(t_kind kind, logic [15:0] ch);
        step_beats[step_count] = '{kind: kind, entry_id: cur_id, char_out: ch,
                                   last_of_step: 1'b0};
        step_count++;
    endfunction

    // one code unit through the grammar, results go to the expected queue
    function automatic void parse_code_unit(t_in_beat beat);
        logic [15:0] cu;
        cu = beat.code_unit;
        step_count = 0;
        if (beat.first_of_file) begin
            parse_mode = MODE_NEWLINE;
            cur_id     = '0;
            pend_bs    = 1'b0;
        end
        // a mark on the first unit of a file is dropped
        if (!(beat.first_of_file && cu == UNIT_BOM)) begin
            case (parse_mode)
                MODE_NEWLINE: begin
                    if (is_digit(cu)) begin
                        cur_id     = 32'(cu - UNIT_DIGIT_0);
                        parse_mode = MODE_NUMBER;
                    end else begin
                        parse_mode = MODE_COMMENT;
                    end
                end
                MODE_COMMENT: begin
                    if (cu == UNIT_LF) parse_mode = MODE_NEWLINE;
                end
                MODE_NUMBER: begin
                    if (is_digit(cu)) begin
                        cur_id = cur_id * 32'd10 + 32'(cu - UNIT_DIGIT_0);
                    end else if (cu == UNIT_EQUALS) begin
                        parse_mode = MODE_QUOTE;
                    end else begin
                        add_result(KIND_ERROR, '0);
                        parse_mode = MODE_HALTED;
                    end
                end
                MODE_QUOTE: begin
                    if (cu == UNIT_QUOTE) begin
                        pend_bs    = 1'b0;
                        parse_mode = MODE_STRING;
                    end else if (cu == UNIT_LF) begin
                        parse_mode = MODE_NEWLINE;
                    end
                end
                MODE_STRING: begin
                    if (pend_bs && cu == UNIT_LOWER_N) begin
                        // newline escape expands to two characters
                        pend_bs = 1'b0;
                        add_result(KIND_CHAR, UNIT_CR);
                        add_result(KIND_CHAR, UNIT_LF);
                    end else begin
                        if (pend_bs) begin
                            pend_bs = 1'b0;
                            add_result(KIND_CHAR, UNIT_BACKSLASH);
                        end
                        if (cu == UNIT_QUOTE) begin
                            add_result(KIND_COMPLETE, '0);
                            parse_mode = MODE_COMMENT;
                        end else if (cu == UNIT_BACKSLASH) begin
                            pend_bs = 1'b1;
                        end else begin
                            add_result(KIND_CHAR, cu);
                        end
                    end
                end
                default: ;
            endcase
            // file end inside an open string
            if (beat.last_of_file && parse_mode == MODE_STRING) begin
                add_result(KIND_ABANDON, '0);
                pend_bs    = 1'b0;
                parse_mode = MODE_NEWLINE;
            end
        end
        if (step_count > 0) step_beats[step_count-1].last_of_step = 1'b1;
        for (int k = 0; k < step_count; k++) expected_results.push_back(step_beats[k]);
    endfunction

    function automatic void report_failure(string what, t_out_beat exp_beat,
                                           t_out_beat act_beat);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t: %s: expected kind %0d id %0d char %h last %b,",
                     $realtime, what, exp_beat.kind, exp_beat.entry_id,
                     exp_beat.char_out, exp_beat.last_of_step);
            $display("    got kind %0d id %0d char %h last %b",
                     act_beat.kind, act_beat.entry_id, act_beat.char_out,
                     act_beat.last_of_step);
        end
    endfunction

    // compare leaving beats first, then predict the accepted unit
    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        if (!i_rst_n) begin
            parse_mode = MODE_NEWLINE;
            cur_id     = '0;
            pend_bs    = 1'b0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (expected_results.size() == 0) begin
                    report_failure("unexpected result beat", '0, i_out_beat);
                end else begin
                    exp_beat = expected_results.pop_front();
                    if (exp_beat.kind !== i_out_beat.kind ||
                        exp_beat.entry_id !== i_out_beat.entry_id ||
                        exp_beat.char_out !== i_out_beat.char_out ||
                        exp_beat.last_of_step !== i_out_beat.last_of_step) begin
                        report_failure("result mismatch", exp_beat, i_out_beat);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) parse_code_unit(i_in_beat);
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the id/string line parser with a directed text and then random
// files of id = "string" lines, comments and broken lines, under three
// idle and stall patterns; the result checker judges every result beat.
// ----------------------------------------------------------------------------
module testbench;
    import idsp_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int UNITS_PER_PHASE = 25;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    t_in_beat  i_beat;
    logic      o_stall;
    logic      o_valid;
    t_out_beat o_beat;
    logic      i_stall;

    int          fail_count;
    int          pending_results;
    int          checked_results;
    int          idle_pct;
    int          stall_pct;
    int          units_sent;
    int          files_sent;
    int          phase_units;
    int          cycle_count;
    logic [15:0] file_units [$];

    id_string_line_parser_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_beat  (i_beat),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_beat  (o_beat),
        .i_stall (i_stall)
    );

    idsp_result_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_beat    (i_beat),
        .i_in_stall   (o_stall),
        .i_out_valid  (o_valid),
        .i_out_beat   (o_beat),
        .i_out_stall  (i_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_checked    (checked_results)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_unit(input logic [15:0] unit, input logic sof, input logic eof);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_beat  <= '{code_unit: unit, first_of_file: sof, last_of_file: eof};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        units_sent++;
        phase_units++;
    endtask

    function automatic logic [15:0] random_unit();
        case ($urandom_range(7))
            0: return UNIT_QUOTE;
            1: return UNIT_BACKSLASH;
            2: return UNIT_LF;
            3: return UNIT_EQUALS;
            4: return 16'(UNIT_DIGIT_0 + $urandom_range(9));
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // entry line with random content, at times with junk or no closing quote
    task automatic add_entry_line();
        int n_digits;
        int n_chars;
        int pick;
        n_digits = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
        repeat (n_digits) file_units.push_back(16'(UNIT_DIGIT_0 + $urandom_range(9)));
        file_units.push_back(UNIT_EQUALS);
        // junk between the equals sign and the quote
        if ($urandom_range(7) == 0) file_units.push_back(random_unit());
        file_units.push_back(UNIT_QUOTE);
        n_chars = $urandom_range(6);
        repeat (n_chars) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                file_units.push_back(UNIT_BACKSLASH);
                file_units.push_back(UNIT_LOWER_N);
            end else if (pick < 25) begin
                file_units.push_back(UNIT_BACKSLASH);
                file_units.push_back(random_unit());
            end else if (pick < 40) begin
                file_units.push_back(16'($urandom_range(16'h7E, 16'h20)));
            end else begin
                file_units.push_back(16'($urandom_range(16'hFFFF)));
            end
        end
        // the closing quote is sometimes missing
        if ($urandom_range(6) != 0) file_units.push_back(UNIT_QUOTE);
        if ($urandom_range(3) == 0) file_units.push_back(random_unit());
        file_units.push_back(UNIT_LF);
    endtask

    // comment line or an id broken by a stray unit
    task automatic add_noise_line(input logic bad_id);
        if (bad_id) begin
            repeat ($urandom_range(1, 3))
                file_units.push_back(16'(UNIT_DIGIT_0 + $urandom_range(9)));
            file_units.push_back(16'($urandom_range(16'hFFFF, 16'h3E)));
        end else begin
            file_units.push_back(16'($urandom_range(16'hFFFF, 16'h3A)));
        end
        repeat ($urandom_range(3)) file_units.push_back(random_unit());
        file_units.push_back(UNIT_LF);
    endtask

    task automatic build_file();
        int pick;
        int cut;
        file_units.delete();
        if ($urandom_range(1) == 1) file_units.push_back(UNIT_BOM);
        repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(99);
            if (pick < 75) add_entry_line();
            else if (pick < 85) add_noise_line(1'b0);
            else if (pick < 93) add_noise_line(1'b1);
            else file_units.push_back(UNIT_LF);
        end
        // cut some files short, often inside a string
        if ($urandom_range(3) == 0) begin
            cut = $urandom_range(file_units.size() - 1);
            file_units = file_units[0:cut];
        end
    endtask

    task automatic send_file();
        for (int k = 0; k < file_units.size(); k++)
            send_unit(file_units[k], k == 0, k == file_units.size() - 1);
        files_sent++;
    endtask

    // directed text: mark skip, escapes, comments, syntax halt, restarts
    task automatic send_directed();
        send_unit(UNIT_BOM, 1'b1, 1'b0);
        send_unit(16'h0039, 1'b0, 1'b0);
        send_unit(UNIT_EQUALS, 1'b0, 1'b0);
        send_unit(16'h0078, 1'b0, 1'b0);
        send_unit(UNIT_QUOTE, 1'b0, 1'b0);
        send_unit(16'hFFFF, 1'b0, 1'b0);
        send_unit(16'h0000, 1'b0, 1'b0);
        send_unit(UNIT_BACKSLASH, 1'b0, 1'b0);
        send_unit(UNIT_LOWER_N, 1'b0, 1'b0);
        send_unit(UNIT_BACKSLASH, 1'b0, 1'b0);
        send_unit(UNIT_BACKSLASH, 1'b0, 1'b0);
        send_unit(UNIT_QUOTE, 1'b0, 1'b0);
        send_unit(UNIT_LF, 1'b0, 1'b0);
        // bare line feed swallows the next line
        send_unit(UNIT_LF, 1'b0, 1'b0);
        send_unit(16'h0035, 1'b0, 1'b0);
        send_unit(UNIT_LF, 1'b0, 1'b0);
        // mark in mid-file is an ordinary unit
        send_unit(UNIT_BOM, 1'b0, 1'b0);
        send_unit(UNIT_LF, 1'b0, 1'b0);
        // syntax error, then silence
        send_unit(16'h0031, 1'b0, 1'b0);
        send_unit(16'h0078, 1'b0, 1'b0);
        send_unit(UNIT_QUOTE, 1'b0, 1'b1);
        // new file, string left open by another file start
        send_unit(16'h0034, 1'b1, 1'b0);
        send_unit(UNIT_EQUALS, 1'b0, 1'b0);
        send_unit(UNIT_QUOTE, 1'b0, 1'b0);
        send_unit(16'h007A, 1'b0, 1'b0);
        send_unit(16'h0038, 1'b1, 1'b0);
        send_unit(UNIT_EQUALS, 1'b0, 1'b0);
        send_unit(UNIT_QUOTE, 1'b0, 1'b0);
        // file end with a backslash pending
        send_unit(UNIT_BACKSLASH, 1'b0, 1'b1);
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_beat      = '0;
        stall_pct   = 0;
        idle_pct    = 0;
        units_sent  = 0;
        files_sent  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct    = (phase == 0) ? 19 : (phase == 1) ? 88 : 0;
            stall_pct  <= (phase == 0) ? 88 : (phase == 1) ? 19 : 0;
            phase_units = 0;
            if (phase == 0) send_directed();
            phase_units = 0;
            while (phase_units < UNITS_PER_PHASE) begin
                build_file();
                send_file();
            end
        end
        i_valid <= 1'b0;

        // drain the results still on their way
        while (pending_results != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("summary: %0d code units in %0d random files plus a directed text,",
                 units_sent, files_sent);
        $display("         %0d result beats checked under three idle and stall patterns",
                 checked_results);
        if (fail_count == 0 && pending_results == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
